// ===== design/dhd_pkg.sv =====
package dhd_pkg;

  localparam int unsigned MAX_CLASSES = 128;
  localparam int unsigned MAX_ANCHORS = 16384;
  localparam int unsigned BOX_FIELDS  = 4;

  localparam int unsigned CORNER_SHIFT = 25;
  localparam int unsigned SIZE_SHIFT   = 24;

  localparam logic [7:0]  MAX_CLASSES_W = 8'(MAX_CLASSES);
  localparam logic [14:0] MAX_ANCHORS_W = 15'(MAX_ANCHORS);

  localparam logic signed [42:0] CORNER_BIAS = 43'sd33554431;
  localparam logic signed [42:0] SIZE_BIAS   = 43'sd16777215;
  localparam logic signed [42:0] SAT_HI      = 43'sd32767;
  localparam logic signed [42:0] SAT_LO      = -43'sd32768;

  localparam logic [1:0] REG_CLASS_COUNT     = 2'd0;
  localparam logic [1:0] REG_ANCHOR_COUNT    = 2'd1;
  localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_SCALE_FACTOR    = 2'd3;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] w;
    logic signed [23:0] h;
    logic signed [23:0] score;
    logic [6:0]         class_id;
    logic [13:0]        anchor_index;
    logic               last_anchor;
  } row_t;

  function automatic logic signed [15:0] trunc_sat(input logic signed [42:0] p,
                                                   input logic corner);
    logic signed [42:0] bias;
    logic signed [42:0] sum;
    logic signed [42:0] q;
    bias = '0;
    if (p[42]) begin
      bias = corner ? CORNER_BIAS : SIZE_BIAS;
    end
    sum = p + bias;
    q = corner ? (sum >>> CORNER_SHIFT) : (sum >>> SIZE_SHIFT);
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[15:0];
  endfunction

endpackage

// ===== design/detection_head_decode_core.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_stall   in_value (Q11.12 row element)
// out      out_valid/out_stall keep, box, class, confidence, anchor position
// cfg      cfg_we              cfg_index, cfg_wdata
//
// One element accepted per cycle while in_stall is low; the result of the element
// that closes a row passes the row register, product register and output register.
// Elements that do not close a row are never stalled; a row end stalls only
// when all three stages are full and out_stall is high.
// Synchronous reset clears counters, running maximum and all valid flags.
module detection_head_decode_core
  import dhd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_keep,
  output logic signed [15:0] out_box_left,
  output logic signed [15:0] out_box_top,
  output logic signed [15:0] out_box_width,
  output logic signed [15:0] out_box_height,
  output logic [6:0]         out_class_id,
  output logic signed [23:0] out_confidence,
  output logic [13:0]        out_anchor_index,
  output logic               out_last_anchor,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [22:0]        cfg_wdata
);

  logic [7:0]  class_count_r;
  logic [14:0] anchor_count_r;
  logic [22:0] threshold_r;
  logic [15:0] scale_r;

  logic row_valid;
  row_t row;
  logic row_take;

  logic               prod_valid_r, prod_valid_nxt;
  logic signed [42:0] p_left_r, p_top_r, p_w_r, p_h_r;
  logic signed [23:0] p_score_r;
  logic [6:0]         p_class_r;
  logic [13:0]        p_anchor_r;
  logic               p_last_r;
  logic               prod_ready;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ready;
  logic               keep_r;
  logic signed [15:0] left_r, top_r, width_r, height_r;
  logic [6:0]         class_r;
  logic signed [23:0] conf_r;
  logic [13:0]        anchor_r;
  logic               last_r;

  logic signed [16:0] factor;
  logic signed [25:0] corner_x, corner_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r  <= 8'd80;
      anchor_count_r <= 15'd8400;
      threshold_r    <= 23'd1024;
      scale_r        <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_COUNT:     class_count_r  <= cfg_wdata[7:0];
        REG_ANCHOR_COUNT:    anchor_count_r <= cfg_wdata[14:0];
        REG_SCORE_THRESHOLD: threshold_r    <= cfg_wdata;
        REG_SCALE_FACTOR:    scale_r        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  dhd_row_acc u_row_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_value     (in_value),
    .in_stall     (in_stall),
    .class_count  (class_count_r),
    .anchor_count (anchor_count_r),
    .row_take     (row_take),
    .row_valid    (row_valid),
    .row          (row)
  );

  assign out_ready  = !out_valid_r || !out_stall;
  assign prod_ready = !prod_valid_r || out_ready;
  assign row_take   = row_valid && prod_ready;

  assign factor   = $signed({1'b0, scale_r});
  assign corner_x = $signed({row.cx[23], row.cx, 1'b0}) - 26'(row.w);
  assign corner_y = $signed({row.cy[23], row.cy, 1'b0}) - 26'(row.h);

  assign prod_valid_nxt = row_take || (prod_valid_r && !out_ready);
  assign out_valid_nxt  = (prod_valid_r && out_ready) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (row_take) begin
      p_left_r   <= corner_x * factor;
      p_top_r    <= corner_y * factor;
      p_w_r      <= row.w * factor;
      p_h_r      <= row.h * factor;
      p_score_r  <= row.score;
      p_class_r  <= row.class_id;
      p_anchor_r <= row.anchor_index;
      p_last_r   <= row.last_anchor;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid_r && out_ready) begin
      keep_r   <= p_score_r > $signed({1'b0, threshold_r});
      left_r   <= trunc_sat(p_left_r, 1'b1);
      top_r    <= trunc_sat(p_top_r, 1'b1);
      width_r  <= trunc_sat(p_w_r, 1'b0);
      height_r <= trunc_sat(p_h_r, 1'b0);
      class_r  <= p_class_r;
      conf_r   <= p_score_r;
      anchor_r <= p_anchor_r;
      last_r   <= p_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_keep         = keep_r;
  assign out_box_left     = left_r;
  assign out_box_top      = top_r;
  assign out_box_width    = width_r;
  assign out_box_height   = height_r;
  assign out_class_id     = class_r;
  assign out_confidence   = conf_r;
  assign out_anchor_index = anchor_r;
  assign out_last_anchor  = last_r;

  a_stall_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (row_valid && prod_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_prod_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_valid_r && out_valid_r && out_stall) |=> prod_valid_r)
    else $error("product stage dropped while output stalled");

  a_keep_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_keep) |-> !out_confidence[23])
    else $error("keep set for a negative score");

endmodule

// ===== design/dhd_row_acc.sv =====
module dhd_row_acc
  import dhd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [23:0] in_value,
  output logic               in_stall,
  input  logic [7:0]         class_count,
  input  logic [14:0]        anchor_count,
  input  logic               row_take,
  output logic               row_valid,
  output row_t               row
);

  logic [7:0]         pos_r, pos_nxt;
  logic signed [23:0] box_r   [BOX_FIELDS];
  logic signed [23:0] box_nxt [BOX_FIELDS];
  logic signed [23:0] best_r, best_nxt;
  logic [6:0]         best_cls_r, best_cls_nxt;
  logic [13:0]        anchor_r, anchor_nxt;
  logic               row_valid_r, row_valid_nxt;
  row_t               row_r, row_nxt;

  logic [7:0]  cls_eff;
  logic [8:0]  row_end_pos;
  logic        row_end;
  logic [14:0] anchors_eff;
  logic        last;
  logic        accept;
  logic [7:0]  cls_idx;

  always_comb begin
    if (class_count == '0) begin
      cls_eff = 8'd1;
    end else if (class_count > MAX_CLASSES_W) begin
      cls_eff = MAX_CLASSES_W;
    end else begin
      cls_eff = class_count;
    end
    if (anchor_count == '0) begin
      anchors_eff = 15'd1;
    end else if (anchor_count > MAX_ANCHORS_W) begin
      anchors_eff = MAX_ANCHORS_W;
    end else begin
      anchors_eff = anchor_count;
    end
  end

  assign row_end_pos = {1'b0, cls_eff} + 9'(BOX_FIELDS - 1);
  assign row_end     = {1'b0, pos_r} >= row_end_pos;
  assign last        = ({1'b0, anchor_r} + 15'd1) >= anchors_eff;
  assign cls_idx     = pos_r - 8'(BOX_FIELDS);

  assign in_stall = row_end && row_valid_r && !row_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_nxt      = pos_r;
    box_nxt      = box_r;
    best_nxt     = best_r;
    best_cls_nxt = best_cls_r;
    anchor_nxt   = anchor_r;
    if (accept) begin
      if (pos_r < 8'(BOX_FIELDS)) begin
        box_nxt[pos_r[1:0]] = in_value;
      end else if (cls_idx == '0 || in_value > best_r) begin
        best_nxt     = in_value;
        best_cls_nxt = cls_idx[6:0];
      end
      if (row_end) begin
        pos_nxt    = '0;
        anchor_nxt = last ? '0 : anchor_r + 14'd1;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_comb begin
    row_nxt              = row_r;
    row_valid_nxt        = row_valid_r && !row_take;
    if (accept && row_end) begin
      row_valid_nxt      = 1'b1;
      row_nxt.cx           = box_r[0];
      row_nxt.cy           = box_r[1];
      row_nxt.w            = box_r[2];
      row_nxt.h            = box_r[3];
      row_nxt.score        = best_nxt;
      row_nxt.class_id     = best_cls_nxt;
      row_nxt.anchor_index = anchor_r;
      row_nxt.last_anchor  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      box_r       <= '{default: '0};
      best_r      <= '0;
      best_cls_r  <= '0;
      anchor_r    <= '0;
      row_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      box_r       <= box_nxt;
      best_r      <= best_nxt;
      best_cls_r  <= best_cls_nxt;
      anchor_r    <= anchor_nxt;
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row_valid = row_valid_r;
  assign row       = row_r;

endmodule
